FILE: hw/rtl/rtf_pkg.sv
// ----------------------------------------------------------------------------
// rtf_pkg: shared types and constants of the ray / triangle first-hit unit
// Payload structs, ray register set, candidate entry and datapath widths.
// ----------------------------------------------------------------------------
package rtf_pkg;

	// Accumulator width: triple products of 33-bit differences reach ~2^100
	localparam int ACC_W = 104;
	// Divider width: |tn| << 16 and det << 31 both stay below 2^132
	localparam int DIV_W = 132;
	localparam int CNT_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 3'd6;

	localparam logic [31:0] DIR_Z_RESET   = 32'h0001_0000;
	localparam logic [15:0] EPS_RESET     = 16'd1;
	localparam logic [31:0] MISS_DISTANCE = 32'hFFFF_0000;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
		logic               last_triangle;
	} rtf_in_t;

	typedef struct packed {
		logic               hit;
		logic [15:0]        hit_index;
		logic signed [31:0] hit_distance;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} rtf_out_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic [15:0]        epsilon;
	} rtf_ray_t;

	// One classified triangle handed from front to back
	typedef struct packed {
		logic                    last;
		logic [CNT_W-1:0]        index;
		logic                    cand;
		logic signed [ACC_W-1:0] det;
		logic signed [ACC_W-1:0] tn;
	} rtf_cand_t;

endpackage

FILE: hw/rtl/rtf_front.sv
// ----------------------------------------------------------------------------
// rtf_front: triangle intake and culling tests
// Forms edges, runs the cross and dot products on one shared multiplier
// with a wide accumulator, classifies the triangle and queues it.
// ----------------------------------------------------------------------------
module rtf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  rtf_pkg::rtf_ray_t  ray,
	input  logic               tri_valid,
	output logic               tri_stall,
	input  rtf_pkg::rtf_in_t   tri_data,
	output logic               push,
	output rtf_pkg::rtf_cand_t push_data,
	input  logic               full
);
	import rtf_pkg::*;

	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_MAC   = 3'd1;
	localparam logic [2:0] F_DRAIN = 3'd2;
	localparam logic [2:0] F_CHK1  = 3'd3;
	localparam logic [2:0] F_CHK2  = 3'd4;
	localparam logic [2:0] F_PUSH  = 3'd5;

	// Operand pool A: D, E1, E2, S
	localparam logic [3:0] A_D  = 4'd0;
	localparam logic [3:0] A_E1 = 4'd3;
	localparam logic [3:0] A_E2 = 4'd6;
	localparam logic [3:0] A_S  = 4'd9;
	// Operand pool B: E2, E1, P low/high, Q low/high
	localparam logic [4:0] B_E2 = 5'd0;
	localparam logic [4:0] B_E1 = 5'd3;
	localparam logic [4:0] B_P  = 5'd6;
	localparam logic [4:0] B_Q  = 5'd12;
	localparam logic [4:0] B_HI = 5'd3;

	// Destinations of a finished sum
	localparam logic [3:0] DST_P   = 4'd0;
	localparam logic [3:0] DST_Q   = 4'd3;
	localparam logic [3:0] DST_DOT = 4'd4;
	localparam logic [3:0] DST_DET = 4'd6;
	localparam logic [3:0] DST_UN  = 4'd7;
	localparam logic [3:0] DST_VN  = 4'd8;
	localparam logic [3:0] DST_TN  = 4'd9;

	localparam logic [2:0] PH_LAST  = 3'd5;
	localparam logic [2:0] SUB_LAST = 3'd5;

	logic [2:0]              st_q;
	logic signed [32:0]      e1_q [3];
	logic signed [32:0]      e2_q [3];
	logic signed [32:0]      s_q  [3];
	logic signed [65:0]      p_q  [3];
	logic signed [65:0]      q_q  [3];
	logic signed [ACC_W-1:0] det_q, un_q, vn_q, tn_q, uv_q, acc_q;
	logic                    last_q;
	logic [CNT_W-1:0]        idx_q, cnt_q;
	logic [2:0]              phase_q, sub_q;
	logic                    det_ok_q, un_ok_q, cand_q;

	logic signed [67:0]      prod_s1;
	logic                    v_s1, sub_s1, sh_s1, clr_s1, st_s1;
	logic [3:0]              dst_s1;

	logic [1:0]              k, k1, k2;
	logic                    j;
	logic [3:0]              a_base, a_sel;
	logic [4:0]              b_base, b_sel;
	logic                    sub_op, sh, clr, stv;
	logic [3:0]              dst;
	logic signed [33:0]      opa, opb;
	logic signed [ACC_W-1:0] ext, acc_sum;
	logic [ACC_W-1:0]        eps_sh;
	logic                    accept;

	assign accept    = tri_valid && !tri_stall;
	assign tri_stall = (st_q != F_IDLE);
	assign eps_sh    = ACC_W'({ray.epsilon, 32'b0});

	// Decode the current multiply step
	always_comb begin
		k  = sub_q[2:1];
		j  = sub_q[0];
		k1 = (k == 2'd2) ? 2'd0 : k + 2'd1;
		k2 = (k == 2'd0) ? 2'd2 : k - 2'd1;
		case (phase_q)
			3'd0:    begin a_base = A_D;  b_base = B_E2; end
			3'd1:    begin a_base = A_S;  b_base = B_E1; end
			3'd2:    begin a_base = A_E1; b_base = B_P;  end
			3'd3:    begin a_base = A_S;  b_base = B_P;  end
			3'd4:    begin a_base = A_D;  b_base = B_Q;  end
			default: begin a_base = A_E2; b_base = B_Q;  end
		endcase
		if (phase_q < 3'd2) begin
			// cross product: c_k = a_k1*b_k2 - a_k2*b_k1
			a_sel  = a_base + {2'b0, (j ? k2 : k1)};
			b_sel  = b_base + {3'b0, (j ? k1 : k2)};
			sub_op = j;
			sh     = 1'b0;
			clr    = !j;
			stv    = j;
			dst    = ((phase_q == 3'd0) ? DST_P : DST_Q) + {2'b0, k};
		end else begin
			// dot product against a split 66-bit vector: low then high half
			a_sel  = a_base + {2'b0, k};
			b_sel  = b_base + (j ? B_HI : 5'd0) + {3'b0, k};
			sub_op = 1'b0;
			sh     = j;
			clr    = (sub_q == 3'd0);
			stv    = (sub_q == SUB_LAST);
			dst    = {1'b0, phase_q} + DST_DOT;
		end
	end

	// Select operand A
	always_comb begin
		case (a_sel)
			4'd0:    opa = 34'(ray.dir_x);
			4'd1:    opa = 34'(ray.dir_y);
			4'd2:    opa = 34'(ray.dir_z);
			4'd3:    opa = 34'(e1_q[0]);
			4'd4:    opa = 34'(e1_q[1]);
			4'd5:    opa = 34'(e1_q[2]);
			4'd6:    opa = 34'(e2_q[0]);
			4'd7:    opa = 34'(e2_q[1]);
			4'd8:    opa = 34'(e2_q[2]);
			4'd9:    opa = 34'(s_q[0]);
			4'd10:   opa = 34'(s_q[1]);
			4'd11:   opa = 34'(s_q[2]);
			default: opa = '0;
		endcase
	end

	// Select operand B
	always_comb begin
		case (b_sel)
			5'd0:    opb = 34'(e2_q[0]);
			5'd1:    opb = 34'(e2_q[1]);
			5'd2:    opb = 34'(e2_q[2]);
			5'd3:    opb = 34'(e1_q[0]);
			5'd4:    opb = 34'(e1_q[1]);
			5'd5:    opb = 34'(e1_q[2]);
			5'd6:    opb = $signed({1'b0, p_q[0][32:0]});
			5'd7:    opb = $signed({1'b0, p_q[1][32:0]});
			5'd8:    opb = $signed({1'b0, p_q[2][32:0]});
			5'd9:    opb = 34'($signed(p_q[0][65:33]));
			5'd10:   opb = 34'($signed(p_q[1][65:33]));
			5'd11:   opb = 34'($signed(p_q[2][65:33]));
			5'd12:   opb = $signed({1'b0, q_q[0][32:0]});
			5'd13:   opb = $signed({1'b0, q_q[1][32:0]});
			5'd14:   opb = $signed({1'b0, q_q[2][32:0]});
			5'd15:   opb = 34'($signed(q_q[0][65:33]));
			5'd16:   opb = 34'($signed(q_q[1][65:33]));
			5'd17:   opb = 34'($signed(q_q[2][65:33]));
			default: opb = '0;
		endcase
	end

	// Accumulate the registered product
	always_comb begin
		ext     = ACC_W'(prod_s1);
		if (sh_s1) ext = ext <<< 33;
		acc_sum = (clr_s1 ? '0 : acc_q) + (sub_s1 ? -ext : ext);
	end

	// Multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (st_q == F_MAC);
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
		sub_s1  <= sub_op;
		sh_s1   <= sh;
		clr_s1  <= clr;
		st_s1   <= stv;
		dst_s1  <= dst;
	end

	// Accumulator and result registers
	always_ff @(posedge clk) begin
		if (v_s1) begin
			acc_q <= acc_sum;
			if (st_s1) begin
				case (dst_s1)
					4'd0:    p_q[0] <= acc_sum[65:0];
					4'd1:    p_q[1] <= acc_sum[65:0];
					4'd2:    p_q[2] <= acc_sum[65:0];
					4'd3:    q_q[0] <= acc_sum[65:0];
					4'd4:    q_q[1] <= acc_sum[65:0];
					4'd5:    q_q[2] <= acc_sum[65:0];
					DST_DET: det_q  <= acc_sum;
					DST_UN:  un_q   <= acc_sum;
					DST_VN:  vn_q   <= acc_sum;
					DST_TN:  tn_q   <= acc_sum;
					default: ;
				endcase
			end
		end
		if (accept) begin
			e1_q[0] <= 33'(tri_data.b_x) - 33'(tri_data.a_x);
			e1_q[1] <= 33'(tri_data.b_y) - 33'(tri_data.a_y);
			e1_q[2] <= 33'(tri_data.b_z) - 33'(tri_data.a_z);
			e2_q[0] <= 33'(tri_data.c_x) - 33'(tri_data.a_x);
			e2_q[1] <= 33'(tri_data.c_y) - 33'(tri_data.a_y);
			e2_q[2] <= 33'(tri_data.c_z) - 33'(tri_data.a_z);
			s_q[0]  <= 33'(ray.origin_x) - 33'(tri_data.a_x);
			s_q[1]  <= 33'(ray.origin_y) - 33'(tri_data.a_y);
			s_q[2]  <= 33'(ray.origin_z) - 33'(tri_data.a_z);
			last_q  <= tri_data.last_triangle;
			idx_q   <= cnt_q;
		end
		if (st_q == F_CHK1) begin
			det_ok_q <= !det_q[ACC_W-1] && (det_q != '0) && ($unsigned(det_q) >= eps_sh);
			un_ok_q  <= !un_q[ACC_W-1] && (un_q <= det_q);
			uv_q     <= un_q + vn_q;
		end
		if (st_q == F_CHK2) begin
			cand_q <= det_ok_q && un_ok_q && !vn_q[ACC_W-1] && (uv_q <= det_q);
		end
	end

	// Sequencer and face position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= F_IDLE;
			phase_q <= '0;
			sub_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (st_q)
				F_IDLE: begin
					if (accept) begin
						cnt_q   <= tri_data.last_triangle ? '0 : cnt_q + 1'b1;
						phase_q <= '0;
						sub_q   <= '0;
						st_q    <= F_MAC;
					end
				end
				F_MAC: begin
					if (sub_q == SUB_LAST) begin
						sub_q <= '0;
						if (phase_q == PH_LAST) st_q <= F_DRAIN;
						else phase_q <= phase_q + 3'd1;
					end else begin
						sub_q <= sub_q + 3'd1;
					end
				end
				F_DRAIN: st_q <= F_CHK1;
				F_CHK1:  st_q <= F_CHK2;
				F_CHK2:  st_q <= F_PUSH;
				F_PUSH: begin
					if (!full) st_q <= F_IDLE;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	assign push      = (st_q == F_PUSH) && !full;
	assign push_data = '{last: last_q, index: idx_q, cand: cand_q, det: det_q, tn: tn_q};

	// The accumulator is quiet while waiting for a triangle
	a_idle_no_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == F_IDLE) |-> !v_s1)
		else $error("multiply stage active while front idle");

endmodule

FILE: hw/rtl/rtf_queue.sv
// ----------------------------------------------------------------------------
// rtf_queue: short queue between front and back
// Holds classified triangles so each side stalls on its own.
// ----------------------------------------------------------------------------
module rtf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rtf_pkg::rtf_cand_t push_data,
	output logic               full,
	input  logic               pop,
	output rtf_pkg::rtf_cand_t head,
	output logic               empty
);
	import rtf_pkg::*;

	rtf_cand_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// Store a beat
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

FILE: hw/rtl/rtf_back.sv
// ----------------------------------------------------------------------------
// rtf_back: distance divide, hit point and face result
// Divides tn by det for surviving candidates, forms the saturated point,
// tracks the face hit flag and drives the result register.
// ----------------------------------------------------------------------------
module rtf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rtf_pkg::rtf_ray_t  ray,
	input  rtf_pkg::rtf_cand_t head,
	input  logic               empty,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output rtf_pkg::rtf_out_t  res_data
);
	import rtf_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_SAT  = 3'd1;
	localparam logic [2:0] B_DIV  = 3'd2;
	localparam logic [2:0] B_TCHK = 3'd3;
	localparam logic [2:0] B_MUL  = 3'd4;
	localparam logic [2:0] B_OUT  = 3'd5;

	localparam logic [4:0]  TOP_BIT = 5'd30;
	localparam logic [30:0] T_MAX   = '1;
	localparam logic [1:0]  M_DONE  = 2'd3;
	localparam logic signed [48:0] SAT_HI = 49'sh0_7FFF_FFFF;
	localparam logic signed [48:0] SAT_LO = -49'sh0_8000_0000;

	localparam rtf_out_t MISS = '{hit: 1'b0, hit_index: '0, hit_distance: MISS_DISTANCE,
		point_x: '0, point_y: '0, point_z: '0};

	logic [2:0]              st_q;
	logic                    hit_seen_q, last_q, tneg_q;
	logic [CNT_W-1:0]        idx_q;
	logic signed [ACC_W-1:0] det_q;
	logic [DIV_W-1:0]        mag_q, r_q, dsh_q, det_w;
	logic [30:0]             quo_q, t_q, quo_nx;
	logic [4:0]              bit_q;
	logic [1:0]              mcnt_q, midx_s1;
	logic                    mv_s1;
	logic signed [63:0]      prod_s1;
	rtf_out_t                res_q, out_q;
	logic                    out_valid_q;

	logic signed [ACC_W-1:0] tn_abs;
	logic                    ge;
	logic signed [31:0]      dsel, osel;
	logic signed [48:0]      psum;
	logic signed [31:0]      psat;

	assign pop       = (st_q == B_IDLE) && !empty;
	assign det_w     = DIV_W'($unsigned(det_q));
	assign tn_abs    = head.tn[ACC_W-1] ? -head.tn : head.tn;
	assign ge        = (r_q >= dsh_q);
	assign quo_nx    = quo_q | (ge ? (31'd1 << bit_q) : '0);
	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	// Pick the axis for the point multiply and add
	always_comb begin
		case (mcnt_q)
			2'd0:    dsel = ray.dir_x;
			2'd1:    dsel = ray.dir_y;
			default: dsel = ray.dir_z;
		endcase
		case (midx_s1)
			2'd0:    osel = ray.origin_x;
			2'd1:    osel = ray.origin_y;
			default: osel = ray.origin_z;
		endcase
		psum = 49'(osel) + 49'(prod_s1 >>> 16);
		if (psum > SAT_HI)      psat = 32'sh7FFF_FFFF;
		else if (psum < SAT_LO) psat = 32'sh8000_0000;
		else                    psat = psum[31:0];
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			last_q <= head.last;
			idx_q  <= head.index;
			det_q  <= head.det;
			tneg_q <= head.tn[ACC_W-1];
			mag_q  <= DIV_W'($unsigned(tn_abs)) << 16;
		end
		if (st_q == B_SAT) begin
			r_q   <= mag_q;
			dsh_q <= det_w << 30;
			bit_q <= TOP_BIT;
			quo_q <= '0;
		end
		if (st_q == B_DIV) begin
			if (ge) r_q <= r_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= quo_nx;
			bit_q <= bit_q - 5'd1;
		end
		prod_s1 <= dsel * $signed({1'b0, t_q});
		midx_s1 <= mcnt_q;
		if (mv_s1) begin
			case (midx_s1)
				2'd0:    res_q.point_x <= psat;
				2'd1:    res_q.point_y <= psat;
				default: res_q.point_z <= psat;
			endcase
		end
		if (st_q == B_MUL && mcnt_q == M_DONE) begin
			res_q.hit          <= 1'b1;
			res_q.hit_index    <= idx_q;
			res_q.hit_distance <= $signed({1'b0, t_q});
		end
		if (pop && head.last && !hit_seen_q && !head.cand) res_q <= MISS;
		if ((st_q == B_SAT || st_q == B_TCHK) && last_q) res_q <= MISS;
		if (st_q == B_OUT && (!out_valid_q || !res_stall)) out_q <= res_q;
	end

	// Control: face hit flag, sequencing, result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			hit_seen_q  <= 1'b0;
			mcnt_q      <= '0;
			mv_s1       <= 1'b0;
			t_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mv_s1 <= (st_q == B_MUL) && (mcnt_q != M_DONE);
			// Load a new beat or drop the one taken
			if (st_q == B_OUT && (!out_valid_q || !res_stall)) out_valid_q <= 1'b1;
			else if (out_valid_q && !res_stall)               out_valid_q <= 1'b0;
			unique case (st_q)
				B_IDLE: begin
					if (pop) begin
						if (!hit_seen_q && head.cand) begin
							st_q <= B_SAT;
						end else if (head.last) begin
							hit_seen_q <= 1'b0;
							if (!hit_seen_q) st_q <= B_OUT;
						end
					end
				end
				B_SAT: begin
					if (tneg_q) begin
						if (mag_q < det_w) begin
							t_q  <= '0;
							st_q <= B_TCHK;
						end else begin
							st_q <= last_q ? B_OUT : B_IDLE;
						end
					end else if (mag_q >= (det_w << 31)) begin
						t_q  <= T_MAX;
						st_q <= B_TCHK;
					end else begin
						st_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (bit_q == '0) begin
						t_q  <= quo_nx;
						st_q <= B_TCHK;
					end
				end
				B_TCHK: begin
					if ({1'b0, t_q} < 32'(ray.epsilon)) begin
						st_q <= last_q ? B_OUT : B_IDLE;
					end else begin
						mcnt_q <= '0;
						st_q   <= B_MUL;
					end
				end
				B_MUL: begin
					if (mcnt_q == M_DONE) begin
						hit_seen_q <= !last_q;
						st_q       <= B_OUT;
					end else begin
						mcnt_q <= mcnt_q + 2'd1;
					end
				end
				B_OUT: begin
					if (!out_valid_q || !res_stall) st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	// Candidate work only runs for a face that has no hit yet
	a_cand_only_unhit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_SAT || st_q == B_DIV || st_q == B_TCHK) |-> !hit_seen_q)
		else $error("candidate processed after face hit");

endmodule

FILE: hw/rtl/ray_triangle_first_hit.sv
// ----------------------------------------------------------------------------
// ray_triangle_first_hit: first hit of a ray against the triangles of a face
// Back-face culled ray / triangle test in Q16.16; one result per face.
// ----------------------------------------------------------------------------
//
//   channel   handshake            beat
//   tri       tri_valid/tri_stall  rtf_in_t: vertices A, B, C, last_triangle
//   res       res_valid/res_stall  rtf_out_t: hit, index, distance, point
//   cfg       cfg_we               cfg_index, cfg_data (ray and epsilon)
//
// The front takes one triangle at a time: 36 steps of its one shared
// multiplier plus drain, the CHK1 and CHK2 compares and the queue push, which
// waits while the queue is full. A surviving candidate then runs through the
// back's bit-serial divider and point multiply; the two-entry queue absorbs this.
// Reset clears control state and loads the ray register defaults; no clearing pass is needed.
// res_stall holds a result in the output register while the next
// triangle is already accepted and worked on.
//
module ray_triangle_first_hit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               tri_valid,
	output logic                               tri_stall,
	input  rtf_pkg::rtf_in_t                   tri_data,
	output logic                               res_valid,
	input  logic                               res_stall,
	output rtf_pkg::rtf_out_t                  res_data,
	input  logic                               cfg_we,
	input  logic [rtf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                        cfg_data
);
	import rtf_pkg::*;

	rtf_ray_t  ray_q;
	rtf_cand_t push_data, head;
	logic      push, full, pop, empty;

	// Hold ray registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_q <= '{origin_x: '0, origin_y: '0, origin_z: '0, dir_x: '0, dir_y: '0,
				dir_z: DIR_Z_RESET, epsilon: EPS_RESET};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X: ray_q.origin_x <= cfg_data;
				REG_ORIGIN_Y: ray_q.origin_y <= cfg_data;
				REG_ORIGIN_Z: ray_q.origin_z <= cfg_data;
				REG_DIR_X:    ray_q.dir_x    <= cfg_data;
				REG_DIR_Y:    ray_q.dir_y    <= cfg_data;
				REG_DIR_Z:    ray_q.dir_z    <= cfg_data;
				REG_EPSILON:  ray_q.epsilon  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	rtf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.ray       (ray_q),
		.tri_valid (tri_valid),
		.tri_stall (tri_stall),
		.tri_data  (tri_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	rtf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	rtf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ray       (ray_q),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule
